// File: src/npr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package npr_pkg;

   // geometry defaults, both powers of two
   localparam int PAGE_BYTES_DEF  = 2048;
   localparam int BLOCK_BYTES_DEF = 131072;

   // result list produced by one item: a leading item plus a nine-item page open
   localparam int RES_MAX   = 10;
   localparam int RES_CNT_W = $clog2(RES_MAX + 1);
   localparam int SEQ_LEN   = 9;
   localparam int COL_W     = 16;

   // request codes
   localparam logic [1:0] FN_START = 2'd0;
   localparam logic [1:0] FN_READY = 2'd1;
   localparam logic [1:0] FN_DATA  = 2'd2;

   // sequencer phases
   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
   localparam logic [PHASE_W-1:0] PH_CHK_READY = 3'd1;
   localparam logic [PHASE_W-1:0] PH_CHK_BYTE  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_RD_READY  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_RD_DATA   = 3'd4;

   // bus operation kinds
   localparam logic [2:0] K_SELECT   = 3'd0;
   localparam logic [2:0] K_DESELECT = 3'd1;
   localparam logic [2:0] K_CMD      = 3'd2;
   localparam logic [2:0] K_ADDR     = 3'd3;
   localparam logic [2:0] K_STROBE   = 3'd4;
   localparam logic [2:0] K_USER     = 3'd5;
   localparam logic [2:0] K_WAIT     = 3'd6;
   localparam logic [2:0] K_DONE     = 3'd7;

   // flash command codes and erased-spare value
   localparam logic [7:0] CMD_READ_SETUP = 8'h00;
   localparam logic [7:0] CMD_READ_START = 8'h30;
   localparam logic [7:0] SPARE_GOOD     = 8'hFF;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] start_addr;
      logic [15:0] length;
      logic [7:0]  flash_byte;
   } req_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [31:0]        addr;
      logic [15:0]        remain;
   } seq_state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] value;
   } res_item_type;

endpackage

`default_nettype wire

// File: src/npr_step.sv
`timescale 1ns / 1ps
`default_nettype none

module npr_step #(
   parameter int PAGE_BYTES  = npr_pkg::PAGE_BYTES_DEF,
   parameter int BLOCK_BYTES = npr_pkg::BLOCK_BYTES_DEF
) (
   input  npr_pkg::seq_state_type cur,
   input  npr_pkg::req_type       req,
   output npr_pkg::seq_state_type nxt,
   output npr_pkg::res_item_type  items [npr_pkg::RES_MAX],
   output logic [npr_pkg::RES_CNT_W-1:0] count
);

   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

   localparam logic [1:0] B_NONE   = 2'd0;
   localparam logic [1:0] B_SEQ    = 2'd1;
   localparam logic [1:0] B_DD     = 2'd2;
   localparam logic [1:0] B_STROBE = 2'd3;

   logic [npr_pkg::PHASE_W-1:0] phase_tmp;
   logic [31:0]                 next_addr;
   logic [15:0]                 next_remain;
   logic [15:0]                 remain_dec;
   logic [31:0]                 addr_inc;
   logic                        pre_v;
   npr_pkg::res_item_type       pre;
   logic [1:0]                  body_sel;
   logic                        force_read;
   logic                        seq_check;
   logic [npr_pkg::COL_W-1:0]   seq_col;
   logic [31:0]                 page;
   npr_pkg::res_item_type       body [npr_pkg::SEQ_LEN];
   logic [npr_pkg::RES_CNT_W-1:0] body_cnt;

   assign remain_dec = cur.remain - 16'd1;
   assign addr_inc   = cur.addr + 32'd1;

   // decide what this item does
   always_comb begin
      phase_tmp   = cur.phase;
      next_addr   = cur.addr;
      next_remain = cur.remain;
      pre_v       = 1'b0;
      pre         = '0;
      body_sel    = B_NONE;
      force_read  = 1'b0;
      case (req.func)
         npr_pkg::FN_START: begin
            if (cur.phase == npr_pkg::PH_IDLE) begin
               next_addr   = req.start_addr;
               next_remain = req.length;
               body_sel    = (req.length == 16'd0) ? B_DD : B_SEQ;
            end
         end
         npr_pkg::FN_READY: begin
            if (cur.phase == npr_pkg::PH_CHK_READY) begin
               body_sel  = B_STROBE;
               phase_tmp = npr_pkg::PH_CHK_BYTE;
            end else if (cur.phase == npr_pkg::PH_RD_READY) begin
               body_sel  = B_STROBE;
               phase_tmp = npr_pkg::PH_RD_DATA;
            end
         end
         npr_pkg::FN_DATA: begin
            if (cur.phase == npr_pkg::PH_CHK_BYTE) begin
               pre_v    = 1'b1;
               pre.kind = npr_pkg::K_DESELECT;
               body_sel = B_SEQ;
               if (req.flash_byte != npr_pkg::SPARE_GOOD) begin
                  // bad block, step to the next one
                  next_addr = cur.addr + 32'(BLOCK_BYTES);
               end else begin
                  force_read = 1'b1;
               end
            end else if (cur.phase == npr_pkg::PH_RD_DATA) begin
               pre_v       = 1'b1;
               pre.kind    = npr_pkg::K_USER;
               pre.value   = req.flash_byte;
               next_addr   = addr_inc;
               next_remain = remain_dec;
               if (remain_dec == 16'd0) begin
                  body_sel  = B_DD;
                  phase_tmp = npr_pkg::PH_IDLE;
               end else if (addr_inc[PAGE_SHIFT-1:0] == '0) begin
                  body_sel = B_SEQ;
               end else begin
                  body_sel = B_STROBE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // page open sequence, spare check at block boundaries
   assign seq_check = !force_read && (next_addr[BLOCK_SHIFT-1:0] == '0);
   assign seq_col   = seq_check ? npr_pkg::COL_W'(PAGE_BYTES)
                                : npr_pkg::COL_W'(next_addr[PAGE_SHIFT-1:0]);
   assign page      = next_addr >> PAGE_SHIFT;

   always_comb begin
      for (int i = 0; i < npr_pkg::SEQ_LEN; i++) begin
         body[i] = '0;
      end
      body_cnt = '0;
      case (body_sel)
         B_SEQ: begin
            body[0] = '{kind: npr_pkg::K_SELECT, value: 8'h00};
            body[1] = '{kind: npr_pkg::K_CMD,    value: npr_pkg::CMD_READ_SETUP};
            body[2] = '{kind: npr_pkg::K_ADDR,   value: seq_col[7:0]};
            body[3] = '{kind: npr_pkg::K_ADDR,   value: seq_col[15:8]};
            body[4] = '{kind: npr_pkg::K_ADDR,   value: page[7:0]};
            body[5] = '{kind: npr_pkg::K_ADDR,   value: page[15:8]};
            body[6] = '{kind: npr_pkg::K_ADDR,   value: page[23:16]};
            body[7] = '{kind: npr_pkg::K_CMD,    value: npr_pkg::CMD_READ_START};
            body[8] = '{kind: npr_pkg::K_WAIT,   value: 8'h00};
            body_cnt = npr_pkg::RES_CNT_W'(npr_pkg::SEQ_LEN);
         end
         B_DD: begin
            body[0] = '{kind: npr_pkg::K_DESELECT, value: 8'h00};
            body[1] = '{kind: npr_pkg::K_DONE,     value: 8'h00};
            body_cnt = npr_pkg::RES_CNT_W'(2);
         end
         B_STROBE: begin
            body[0] = '{kind: npr_pkg::K_STROBE, value: 8'h00};
            body_cnt = npr_pkg::RES_CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // leading item goes first, the body follows it
   always_comb begin
      for (int i = 0; i < npr_pkg::RES_MAX; i++) begin
         if (pre_v) begin
            if (i == 0) begin
               items[i] = pre;
            end else if (i - 1 < npr_pkg::SEQ_LEN) begin
               items[i] = body[i-1];
            end else begin
               items[i] = '0;
            end
         end else if (i < npr_pkg::SEQ_LEN) begin
            items[i] = body[i];
         end else begin
            items[i] = '0;
         end
      end
   end

   assign count = body_cnt + npr_pkg::RES_CNT_W'(pre_v);

   always_comb begin
      nxt.addr   = next_addr;
      nxt.remain = next_remain;
      if (body_sel == B_SEQ) begin
         nxt.phase = seq_check ? npr_pkg::PH_CHK_READY : npr_pkg::PH_RD_READY;
      end else begin
         nxt.phase = phase_tmp;
      end
   end

endmodule

`default_nettype wire

// File: src/npr_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module npr_emit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  npr_pkg::res_item_type          items [npr_pkg::RES_MAX],
   input  logic [npr_pkg::RES_CNT_W-1:0]  count,
   output logic                           free,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_op_kind,
   output logic [7:0]                     rsp_op_value,
   output logic                           rsp_last
);

   npr_pkg::res_item_type         list_ff [npr_pkg::RES_MAX];
   npr_pkg::res_item_type         list_in [npr_pkg::RES_MAX];
   logic [npr_pkg::RES_CNT_W-1:0] count_ff;
   logic [npr_pkg::RES_CNT_W-1:0] count_in;
   logic                          xfer;

   assign rsp_valid    = (count_ff != '0);
   assign xfer         = rsp_valid && !rsp_stall;
   assign free         = (count_ff == '0) ||
                         ((count_ff == npr_pkg::RES_CNT_W'(1)) && !rsp_stall);
   assign rsp_op_kind  = list_ff[0].kind;
   assign rsp_op_value = list_ff[0].value;
   assign rsp_last     = (count_ff == npr_pkg::RES_CNT_W'(1));

   always_comb begin
      list_in  = list_ff;
      count_in = count_ff;
      if (load) begin
         list_in  = items;
         count_in = count;
      end else if (xfer) begin
         for (int i = 0; i < npr_pkg::RES_MAX - 1; i++) begin
            list_in[i] = list_ff[i+1];
         end
         list_in[npr_pkg::RES_MAX-1] = '0;
         count_in = count_ff - npr_pkg::RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      list_ff <= list_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result list loaded while still busy");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= npr_pkg::RES_CNT_W'(npr_pkg::RES_MAX))
      else $error("result count out of range");

   a_count_steps : assert property (@(posedge clock) disable iff (reset)
      (xfer && (count_ff > npr_pkg::RES_CNT_W'(1)))
      |=> (count_ff == $past(count_ff) - npr_pkg::RES_CNT_W'(1)))
      else $error("result count did not step down after transfer");

endmodule

`default_nettype wire

// File: src/nand_page_read_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Large-page NAND read sequencer with bad-block skip. A start request
// (func 0) loads a byte address and length; ready (func 1) and data (func 2)
// requests report flash bus events. Each request produces zero or more bus
// operations on the rsp_ channel, one per transfer, with rsp_last on the
// final one. On every block boundary the spare byte at column PAGE_BYTES of
// the block's first page is read; a value other than 0xFF skips the block.
// A request is taken into an input register, resolved combinationally
// against the sequencer state and written as a whole list into the result
// register, which then drains one operation per cycle while rsp_stall is
// low. Requests that give at most one operation flow at one per cycle when
// rsp_stall is low; a larger list holds the input side until it is down to
// its final operation, set by the single-port drain. A request passes the
// input register and the result register before its first op is offered.
// PAGE_BYTES and BLOCK_BYTES must be powers of two.
module nand_page_read_sequencer_core #(
   parameter int PAGE_BYTES  = npr_pkg::PAGE_BYTES_DEF,
   parameter int BLOCK_BYTES = npr_pkg::BLOCK_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_start_addr,
   input  logic [15:0] req_length,
   input  logic [7:0]  req_flash_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_op_kind,
   output logic [7:0]  rsp_op_value,
   output logic        rsp_last
);

   // input register
   npr_pkg::req_type req_ff;
   logic             req_vld_ff;
   logic             req_vld_in;

   // sequencer state
   npr_pkg::seq_state_type state_ff;
   npr_pkg::seq_state_type state_nxt;

   npr_pkg::res_item_type         items [npr_pkg::RES_MAX];
   logic [npr_pkg::RES_CNT_W-1:0] count;
   logic                          emit_free;
   logic                          advance;
   logic                          req_xfer;

   // request moves on when the result register can take its list
   assign advance   = req_vld_ff && emit_free;
   assign req_stall = req_vld_ff && !emit_free;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      req_vld_in = req_vld_ff;
      if (req_xfer) begin
         req_vld_in = 1'b1;
      end else if (advance) begin
         req_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_ff.func       <= req_func;
         req_ff.start_addr <= req_start_addr;
         req_ff.length     <= req_length;
         req_ff.flash_byte <= req_flash_byte;
      end
      if (reset) begin
         req_vld_ff      <= 1'b0;
         state_ff.phase  <= npr_pkg::PH_IDLE;
         state_ff.addr   <= '0;
         state_ff.remain <= '0;
      end else begin
         req_vld_ff <= req_vld_in;
         // state only changes when a request is resolved
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   npr_step #(
      .PAGE_BYTES (PAGE_BYTES),
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_step (
      .cur  (state_ff),
      .req  (req_ff),
      .nxt  (state_nxt),
      .items(items),
      .count(count)
   );

   // result register and drain
   npr_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .items       (items),
      .count       (count),
      .free        (emit_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_op_kind (rsp_op_kind),
      .rsp_op_value(rsp_op_value),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire
